FILE: sv/tks_pkg.sv
`timescale 1ns / 1ps

package tks_pkg;

  // Sizing of the selector.
  localparam int MAX_TOP     = 16;
  localparam int MAX_CLASSES = 1024;

  // Field widths fixed by the interface.
  localparam int ScoreW = 16;
  localparam int IdxW   = 10;
  localparam int RankW  = 4;
  localparam int TopW   = 5;

  // Derived widths.
  localparam int CntW = $clog2(MAX_TOP + 1);
  localparam int PosW = $clog2(MAX_CLASSES + 1);

  // Reset value of the top count register.
  localparam logic [TopW-1:0] TopReset = TopW'(5);

  // One kept entry of the sorted chain.
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [IdxW-1:0]   index;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic shift_up;
  } cell_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_READOUT
  } state_e;

endpackage

FILE: sv/tks_cell.sv
`timescale 1ns / 1ps

module tks_cell import tks_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  entry_t     new_i,
  input  logic       prev_take_i,
  input  entry_t     prev_i,
  input  entry_t     next_i,
  output logic       take_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // An empty cell always yields; a full one yields only to a strictly higher score,
  // so an earlier arrival with an equal score keeps the better rank.
  assign take_o = !occupied_i || (entry_q.score < new_i.score);

  // Insert: take the left neighbor's word if it moves too, else the new word.
  // Readout: the chain moves one place toward the head.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && take_o) begin
      entry_d = prev_take_i ? prev_i : new_i;
    end else if (ctrl_i.shift_up) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: sv/top_k_score_selector.sv
`timescale 1ns / 1ps

// Streaming top-K selector. A score is taken in every clock cycle with start high and busy
// low; each score goes into a sorted chain of MAX_TOP insertion cells in that same cycle.
// After the score flagged final_score_i, the block raises busy and shows min(K, kept)
// results, one per cycle on consecutive cycles, best first, with result_valid_o high for
// exactly one cycle each, as the cell chain shifts toward its head. The receiver cannot
// stall: every strobed word must be taken. top_count may be written at any time; the
// value in force when the final score is taken decides the number of results. 0 acts as
// 1 and values above MAX_TOP act as MAX_TOP.
module top_k_score_selector import tks_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ScoreW-1:0] score_i,
  input  logic              final_score_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TopW-1:0]   cfg_top_count_i,
  output logic              result_valid_o,
  output logic [ScoreW-1:0] best_score_o,
  output logic [IdxW-1:0]   class_index_o,
  output logic [RankW-1:0]  rank_o,
  output logic              last_result_o,
  output logic              count_overflow_o
);

  state_e          state_q, state_d;
  logic [TopW-1:0] top_q;
  logic [CntW-1:0] count_q, count_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            ovf_q, ovf_d;
  logic            ovf_out_q, ovf_out_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] rd_q, rd_d;

  logic            accept;
  logic            in_range;
  logic            last_rd;
  logic [CntW-1:0] k_eff;
  logic [CntW-1:0] count_next;
  logic [CntW-1:0] n_next;
  cell_ctrl_t      ctrl;
  entry_t          new_word;

  entry_t          cell_entry [MAX_TOP];
  logic            cell_take  [MAX_TOP];

  assign accept   = start && !busy;
  assign in_range = (pos_q < PosW'(MAX_CLASSES));
  assign last_rd  = (rd_q + CntW'(1) == n_q);

  assign new_word.score = score_i;
  assign new_word.index = pos_q[IdxW-1:0];

  // Configuration register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= TopReset;
    end else if (cfg_valid_i) begin
      top_q <= cfg_top_count_i;
    end
  end

  // Effective K and the number of results for the run that ends now.
  always_comb begin
    if (top_q == '0) begin
      k_eff = CntW'(1);
    end else if (int'(top_q) > MAX_TOP) begin
      k_eff = CntW'(MAX_TOP);
    end else begin
      k_eff = CntW'(top_q);
    end
    count_next = count_q;
    if (in_range && (count_q < CntW'(MAX_TOP))) begin
      count_next = count_q + CntW'(1);
    end
    n_next = (count_next < k_eff) ? count_next : k_eff;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (accept && final_score_i && (n_next != '0)) begin
          state_d = ST_READOUT;
        end
      end
      ST_READOUT: begin
        if (last_rd) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // State outputs and cell commands.
  always_comb begin
    busy           = 1'b0;
    result_valid_o = 1'b0;
    ctrl.insert    = 1'b0;
    ctrl.shift_up  = 1'b0;
    case (state_q)
      ST_COLLECT: begin
        ctrl.insert = start && in_range;
      end
      ST_READOUT: begin
        busy           = 1'b1;
        result_valid_o = 1'b1;
        ctrl.shift_up  = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Run bookkeeping: the run state clears as the final score is taken in.
  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    ovf_d     = ovf_q;
    ovf_out_d = ovf_out_q;
    n_d       = n_q;
    rd_d      = rd_q;
    if (accept) begin
      if (final_score_i) begin
        count_d   = '0;
        pos_d     = '0;
        ovf_d     = 1'b0;
        ovf_out_d = ovf_q || !in_range;
        n_d       = n_next;
        rd_d      = '0;
      end else begin
        count_d = count_next;
        if (in_range) begin
          pos_d = pos_q + PosW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end else if (state_q == ST_READOUT) begin
      rd_d = rd_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_COLLECT;
      count_q   <= '0;
      pos_q     <= '0;
      ovf_q     <= 1'b0;
      ovf_out_q <= 1'b0;
      n_q       <= '0;
      rd_q      <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      ovf_q     <= ovf_d;
      ovf_out_q <= ovf_out_d;
      n_q       <= n_d;
      rd_q      <= rd_d;
    end
  end

  // Sorted chain of insertion cells, head at cell 0.
  for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
    logic   prev_take;
    entry_t prev_word;
    entry_t next_word;

    if (i == 0) begin : g_head
      assign prev_take = 1'b0;
      assign prev_word = new_word;
    end else begin : g_body
      assign prev_take = cell_take[i-1];
      assign prev_word = cell_entry[i-1];
    end

    if (i == MAX_TOP - 1) begin : g_tail
      assign next_word = cell_entry[i];
    end else begin : g_inner
      assign next_word = cell_entry[i+1];
    end

    tks_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CntW'(i)),
      .new_i       (new_word),
      .prev_take_i (prev_take),
      .prev_i      (prev_word),
      .next_i      (next_word),
      .take_o      (cell_take[i]),
      .entry_o     (cell_entry[i])
    );
  end

  // Result word comes from the head of the chain.
  assign best_score_o     = cell_entry[0].score;
  assign class_index_o    = cell_entry[0].index;
  assign rank_o           = rd_q[RankW-1:0];
  assign last_result_o    = last_rd;
  assign count_overflow_o = ovf_out_q;

endmodule
